// ===== rtl/swer_pkg.sv =====
// ============================================================================
// swer_pkg - shared types and constants of the sliding window event rate meter
// Opcodes, qualifying message codes, field widths and the event qualifier.
// ============================================================================
`default_nettype none

package swer_pkg;

    typedef logic [1:0] t_op;

    localparam t_op OP_TICK  = 2'd0;
    localparam t_op OP_KEY   = 2'd1;
    localparam t_op OP_MOUSE = 2'd2;

    localparam int CODE_W = 16;
    localparam int CNT_W  = 16;
    localparam int RATE_W = 22;

    // stream bus packing: tdata is padded to whole bytes
    localparam int OUT_TDATA_W = ((RATE_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    // key-up and system-key-up
    localparam logic [CODE_W-1:0] MSG_KEYUP    = 16'h0101;
    localparam logic [CODE_W-1:0] MSG_SYSKEYUP = 16'h0105;
    // left, right, middle and X button-up
    localparam logic [CODE_W-1:0] MSG_LBUTTONUP = 16'h0202;
    localparam logic [CODE_W-1:0] MSG_RBUTTONUP = 16'h0205;
    localparam logic [CODE_W-1:0] MSG_MBUTTONUP = 16'h0208;
    localparam logic [CODE_W-1:0] MSG_XBUTTONUP = 16'h020C;

    function automatic logic is_event(input t_op op, input logic [CODE_W-1:0] code);
        logic hit;
        hit = 1'b0;
        case (op)
            OP_KEY: begin
                hit = (code == MSG_KEYUP) || (code == MSG_SYSKEYUP);
            end
            OP_MOUSE: begin
                hit = (code == MSG_LBUTTONUP) || (code == MSG_RBUTTONUP) ||
                      (code == MSG_MBUTTONUP) || (code == MSG_XBUTTONUP);
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sliding_window_event_rate.sv =====
// ============================================================================
// sliding_window_event_rate - events per sliding window of WINDOW seconds
// Counts key-up and button-up messages per one-second tick, keeps the last
// WINDOW per-second counts in a ring and reports the windowed rate.
// ============================================================================
//
//  channel  | dir | handshake                    | tdata             | tuser
//  ---------+-----+------------------------------+-------------------+-----------
//  s (in)   | in  | i_s_tvalid / o_s_tready      | [15:0] msg_code   | [1:0] op
//  m (out)  | out | o_m_tvalid / i_m_tready      | [21:0] rate, pad  | [0] counted
//
//  Sequencing: a message request's result lands in the output register at
//  the accept edge. A tick steps through accept, ring access + add and
//  subtract once the window is full; during warm-up the bit-serial restoring
//  divider, which shares the one add/subtract unit, and quotient * WINDOW
//  replace the subtract. The first tick's result lands at its accept edge.
//  Reset: synchronous, active low; clears control state, the ring is not
//  cleared since a slot's read value is only used after it was written.
//  Stalls: input is taken only in idle while the output register is free or
//  being drained; tready stays low for the rest of a tick sequence.
//
`default_nettype none

module sliding_window_event_rate
    import swer_pkg::*;
#(
    parameter int WINDOW = 60
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    input  wire [CODE_W-1:0]       i_s_tdata,   // [15:0] msg_code
    input  wire [1:0]              i_s_tuser,   // [1:0] op
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [21:0] rate, [23:22] zero
    output logic [0:0]             o_m_tuser    // [0] counted
);

    // ------------------------------------------------------------------------
    // derived sizes
    // ------------------------------------------------------------------------
    localparam int POS_W  = $clog2(WINDOW);                 // ring index
    localparam int TW     = $clog2(WINDOW + 2);             // holds WINDOW + 1
    localparam int SUM_W  = $clog2(WINDOW * 65535 + 1);     // full window sum
    localparam int STEP_W = $clog2(SUM_W);                  // divider steps
    localparam int PROD_W = SUM_W + $clog2(WINDOW + 1);     // quotient * WINDOW
    localparam int CMP_W  = (PROD_W > RATE_W) ? PROD_W : RATE_W;
    localparam int ALU_W  = SUM_W + 1;                      // top bit = borrow

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;   // ring read/write, sum += count
    localparam logic [2:0] S_SUB  = 3'd2;   // full window: sum -= oldest
    localparam logic [2:0] S_DIV  = 3'd3;   // warm-up: one quotient bit a cycle
    localparam logic [2:0] S_MUL  = 3'd4;   // warm-up: quotient * WINDOW

    function automatic logic [RATE_W-1:0] sat_rate(input logic [CMP_W-1:0] v);
        return (v > CMP_W'(RATE_MAX)) ? RATE_MAX : v[RATE_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------------
    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [TW-1:0]     r_ticks, n_ticks;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [RATE_W-1:0] r_rate, n_rate;
    logic              r_out_valid, n_out_valid;
    logic [STEP_W-1:0] r_step, n_step;

    // payload, no reset
    logic [RATE_W-1:0] r_out_rate, n_out_rate;
    logic              r_out_cnt, n_out_cnt;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [TW-1:0]     r_rem, n_rem;
    logic [TW-1:0]     r_div, n_div;

    // per-second count ring
    logic [CNT_W-1:0]  r_mem [WINDOW];
    logic [CNT_W-1:0]  r_rd_data;
    logic              mem_we;

    // shared add/subtract unit
    logic [ALU_W-1:0]  alu_a, alu_b, alu_res;
    logic              alu_sub;
    logic [TW:0]       div_trial;
    logic [PROD_W-1:0] prod;

    logic              s_acc, out_free, ev_hit;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_rate);
    assign o_m_tuser  = r_out_cnt;

    assign ev_hit    = is_event(i_s_tuser, i_s_tdata) && (r_ticks != '0);
    assign div_trial = {r_rem, r_quo[SUM_W-1]};
    assign prod      = PROD_W'(r_quo) * PROD_W'(WINDOW);

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_ADD: begin
                alu_a = ALU_W'(r_sum);
                alu_b = ALU_W'(r_count);
            end
            S_SUB: begin
                alu_a   = ALU_W'(r_sum);
                alu_b   = ALU_W'(r_rd_data);
                alu_sub = 1'b1;
            end
            S_DIV: begin
                alu_a   = ALU_W'(div_trial);
                alu_b   = ALU_W'(r_div);
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
        alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sum       = r_sum;
        n_ticks     = r_ticks;
        n_pos       = r_pos;
        n_rate      = r_rate;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_rate  = r_out_rate;
        n_out_cnt   = r_out_cnt;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        mem_we      = 1'b0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser == OP_TICK) begin
                        if (r_ticks == '0) begin
                            // first tick opens the first second, rate 0
                            n_rate      = '0;
                            n_count     = '0;
                            n_pos       = '0;
                            n_ticks     = TW'(1);
                            n_out_valid = 1'b1;
                            n_out_rate  = '0;
                            n_out_cnt   = 1'b0;
                        end else begin
                            n_state = S_ADD;
                        end
                    end else begin
                        if (ev_hit && (r_count != CNT_MAX)) begin
                            n_count = r_count + 1'b1;
                        end
                        n_out_valid = 1'b1;
                        n_out_rate  = r_rate;
                        n_out_cnt   = ev_hit;
                    end
                end
            end
            S_ADD: begin
                mem_we  = 1'b1;
                n_sum   = alu_res[SUM_W-1:0];
                n_div   = r_ticks;
                n_quo   = alu_res[SUM_W-1:0];
                n_rem   = '0;
                n_step  = STEP_W'(SUM_W - 1);
                n_count = '0;
                n_pos   = (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + 1'b1;
                if (r_ticks <= TW'(WINDOW)) begin
                    n_ticks = r_ticks + 1'b1;
                end
                n_state = (r_ticks > TW'(WINDOW)) ? S_SUB : S_DIV;
            end
            S_SUB: begin
                n_sum       = alu_res[SUM_W-1:0];
                n_rate      = sat_rate(CMP_W'(alu_res[SUM_W-1:0]));
                n_out_valid = 1'b1;
                n_out_rate  = n_rate;
                n_out_cnt   = 1'b0;
                n_state     = S_IDLE;
            end
            S_DIV: begin
                // restoring step: borrow shows in the top bit of the unit
                if (alu_res[ALU_W-1]) begin
                    n_rem = div_trial[TW-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b0};
                end else begin
                    n_rem = alu_res[TW-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b1};
                end
                if (r_step == '0) begin
                    n_state = S_MUL;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_MUL: begin
                n_rate      = sat_rate(CMP_W'(prod));
                n_out_valid = 1'b1;
                n_out_rate  = n_rate;
                n_out_cnt   = 1'b0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_ticks     <= '0;
            r_pos       <= '0;
            r_rate      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_ticks     <= n_ticks;
            r_pos       <= n_pos;
            r_rate      <= n_rate;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_rate <= n_out_rate;
        r_out_cnt  <= n_out_cnt;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_div      <= n_div;
    end

    // ring: read-before-write at the running slot
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_rd_data    <= r_mem[r_pos];
            r_mem[r_pos] <= r_count;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_ticks_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ticks <= TW'(WINDOW + 1))
        else $error("tick count past window + 1");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_W'(WINDOW))
        else $error("ring position out of range");

    a_tick_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (i_s_tuser == OP_TICK) && (r_ticks != '0)) |=> (r_state == S_ADD))
        else $error("tick did not start the update sequence");

    a_counted_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cnt) |-> (r_ticks != '0))
        else $error("event counted before first tick");

endmodule

`default_nettype wire

// ===== tb/sv/event_rate_checker.sv =====
// ============================================================================
// event_rate_checker - result checker for the sliding window event rate meter
// Watches both stream channels, predicts the rate and counted flag of every
// accepted request and compares each accepted result with the oldest one.
// ============================================================================
`timescale 1ns / 100ps

module event_rate_checker
    import swer_pkg::*;
#(
    parameter int WINDOW = 60
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    input  wire                    i_s_tready,
    input  wire [CODE_W-1:0]       i_s_tdata,   // [15:0] msg_code
    input  wire [1:0]              i_s_tuser,   // [1:0] op
    input  wire                    i_m_tvalid,
    input  wire                    i_m_tready,
    input  wire [OUT_TDATA_W-1:0]  i_m_tdata,   // [21:0] rate, [23:22] zero
    input  wire [0:0]              i_m_tuser,   // [0] counted
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic              counted;
    } t_rate_result;

    localparam int REPORT_LIMIT = 10;

    // predictor state
    logic [CNT_W-1:0]  slot_counts [WINDOW];
    logic [CNT_W-1:0]  run_count;
    int unsigned       held_sum;
    int unsigned       seconds_held;
    int unsigned       slot_idx;
    logic [RATE_W-1:0] last_rate;

    t_rate_result expected_rates[$];

    function automatic t_rate_result predict_rate(input t_op op, input logic [CODE_W-1:0] code);
        t_rate_result res;
        logic         qualifies;
        logic [CNT_W-1:0] leaving;
        int unsigned  raw;
        res.counted = 1'b0;
        case (op)
            OP_KEY: begin
                qualifies = (code == MSG_KEYUP) || (code == MSG_SYSKEYUP);
            end
            OP_MOUSE: begin
                qualifies = (code == MSG_LBUTTONUP) || (code == MSG_RBUTTONUP) ||
                            (code == MSG_MBUTTONUP) || (code == MSG_XBUTTONUP);
            end
            default: begin
                qualifies = 1'b0;
            end
        endcase
        if (op == OP_TICK) begin
            if (seconds_held == 0) begin
                // first tick only opens the first second
                last_rate    = '0;
                run_count    = '0;
                slot_idx     = 0;
                seconds_held = 1;
            end else begin
                if (slot_idx >= WINDOW) begin
                    slot_idx = 0;
                end
                leaving                = slot_counts[slot_idx];
                slot_counts[slot_idx]  = run_count;
                held_sum               = held_sum + run_count;
                if (seconds_held > WINDOW) begin
                    held_sum = held_sum - leaving;
                    raw      = held_sum;
                end else begin
                    // warm-up: average per second scaled to the window
                    raw = (held_sum / seconds_held) * WINDOW;
                end
                last_rate = (raw > RATE_MAX) ? RATE_MAX : raw[RATE_W-1:0];
                slot_idx  = (slot_idx + 1 >= WINDOW) ? 0 : slot_idx + 1;
                run_count = '0;
                if (seconds_held <= WINDOW) begin
                    seconds_held++;
                end
            end
        end else if (qualifies && seconds_held != 0) begin
            if (run_count != CNT_MAX) begin
                run_count++;
            end
            res.counted = 1'b1;
        end
        res.rate = last_rate;
        return res;
    endfunction

    task automatic flag_failure(input string what, input t_rate_result want,
                                input logic [OUT_TDATA_W-1:0] got_data, input logic got_counted);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s: rate exp %0d got %0d, counted exp %0d got %0d", $realtime,
                     what, want.rate, got_data, want.counted, got_counted);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rate_result want;
        if (!i_rst_n) begin
            run_count    = '0;
            held_sum     = 0;
            seconds_held = 0;
            slot_idx     = 0;
            last_rate    = '0;
            expected_rates.delete();
        end else begin
            // retire first so a stray result is never hidden by a new request
            if (i_m_tvalid && i_m_tready) begin
                if (expected_rates.size() == 0) begin
                    want = '0;
                    flag_failure("result with nothing expected", want, i_m_tdata, i_m_tuser[0]);
                end else begin
                    want = expected_rates.pop_front();
                    if (i_m_tdata != OUT_TDATA_W'(want.rate) || i_m_tuser[0] != want.counted) begin
                        flag_failure("result mismatch", want, i_m_tdata, i_m_tuser[0]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_rates.insert(expected_rates.size(),
                                      predict_rate(t_op'(i_s_tuser), i_s_tdata));
            end
        end
        o_pending = expected_rates.size();
    end

endmodule

// ===== tb/sv/sliding_window_event_rate_test.sv =====
// ============================================================================
// sliding_window_event_rate_test - testbench top of the event rate meter
// Drives directed and random tick / keyboard / mouse requests with random
// gaps and stalls on both channels; a checker beside the block predicts and
// compares every result, and this top gives the verdict.
// ============================================================================
`timescale 1ns / 100ps

module sliding_window_event_rate_test;
    import swer_pkg::*;

    localparam int WINDOW        = 60;
    localparam int RANDOM_ITEMS  = 930;    // random requests after the directed ones
    localparam int IDLE_PCT      = 32;
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off, fills the block
    localparam int SETTLE_CYCLES = 40;     // idle time before the verdict
    localparam int STALL_LIMIT   = 2000;   // cycles with no handshake on either side

    localparam t_op               OP_UNUSED       = 2'd3;     // undefined op
    localparam logic [CODE_W-1:0] MSG_KEYDOWN     = 16'h0100;
    localparam logic [CODE_W-1:0] MSG_LBUTTONDOWN = 16'h0201;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [CODE_W-1:0]      i_s_tdata;      // [15:0] msg_code
    logic [1:0]             i_s_tuser;      // [1:0] op
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;      // [21:0] rate, [23:22] zero
    logic [0:0]             o_m_tuser;      // [0] counted

    int   fail_count;
    int   pending;
    logic calm;            // no idling on either side while set
    logic hold_request;    // sender asks the receiver for one long hold-off

    sliding_window_event_rate #(
        .WINDOW (WINDOW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    event_rate_checker #(
        .WINDOW (WINDOW)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Sender helpers. Inputs change on the falling edge; a request is taken
    // at the first rising edge that sees tready high.
    // ------------------------------------------------------------------------
    task automatic send_request(input t_op op, input logic [CODE_W-1:0] code);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= code;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait (pending == 0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_op              op;
        logic [CODE_W-1:0] code;
        int               sent;
        int               pick;
        logic             held_once;
        logic             paused_once;

        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        calm         = 1'b0;
        hold_request = 1'b0;
        held_once    = 1'b0;
        paused_once  = 1'b0;
        sent         = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // events before the first tick are dropped; undefined op is ignored
        send_request(OP_KEY, MSG_KEYUP);
        send_request(OP_MOUSE, MSG_LBUTTONUP);
        send_request(OP_UNUSED, 16'hFFFF);
        // first tick reports zero and starts counting
        send_request(OP_TICK, 16'h0000);
        send_request(OP_TICK, 16'hFFFF);
        // every qualifying message code
        send_request(OP_KEY, MSG_KEYUP);
        send_request(OP_KEY, MSG_SYSKEYUP);
        send_request(OP_MOUSE, MSG_LBUTTONUP);
        send_request(OP_MOUSE, MSG_RBUTTONUP);
        send_request(OP_MOUSE, MSG_MBUTTONUP);
        send_request(OP_MOUSE, MSG_XBUTTONUP);
        // codes on the wrong channel, code extremes, undefined op with a real code
        send_request(OP_KEY, MSG_LBUTTONUP);
        send_request(OP_MOUSE, MSG_KEYUP);
        send_request(OP_KEY, 16'h0000);
        send_request(OP_MOUSE, 16'hFFFF);
        send_request(OP_UNUSED, MSG_KEYUP);
        send_request(OP_TICK, 16'h1234);
        // key-down and button-down do not count
        send_request(OP_KEY, MSG_KEYDOWN);
        send_request(OP_MOUSE, MSG_LBUTTONDOWN);
        send_request(OP_TICK, 16'h0000);
        wait_for_drain();

        // random part: mostly ticks and real events, some noise
        while (sent < RANDOM_ITEMS) begin
            calm = (sent >= 300 && sent < 450);
            if (sent >= 100 && !held_once) begin
                hold_request = 1'b1;
                held_once    = 1'b1;
            end
            if (sent >= 600 && !paused_once) begin
                wait_for_drain();
                paused_once = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                op   = OP_TICK;
                code = CODE_W'($urandom);
            end else if (pick < 70) begin
                case ($urandom_range(0, 5))
                    0: begin op = OP_KEY;   code = MSG_KEYUP;     end
                    1: begin op = OP_KEY;   code = MSG_SYSKEYUP;  end
                    2: begin op = OP_MOUSE; code = MSG_LBUTTONUP; end
                    3: begin op = OP_MOUSE; code = MSG_RBUTTONUP; end
                    4: begin op = OP_MOUSE; code = MSG_MBUTTONUP; end
                    default: begin op = OP_MOUSE; code = MSG_XBUTTONUP; end
                endcase
            end else if (pick < 85) begin
                op   = $urandom_range(0, 1) ? OP_KEY : OP_MOUSE;
                code = CODE_W'($urandom);
            end else if (pick < 93) begin
                op   = OP_UNUSED;
                code = CODE_W'($urandom);
            end else begin
                op   = t_op'($urandom_range(1, 3));
                code = {8'h00, 8'($urandom)} | 16'h0100;
            end
            send_request(op, code);
            sent++;
        end
        calm = 1'b0;

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        i_m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no request moves on either side for too long
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/swer_pkg.sv
rtl/sliding_window_event_rate.sv
tb/sv/event_rate_checker.sv
tb/sv/sliding_window_event_rate_test.sv
